// ===== sv/lsbc_pkg.sv =====
// ----------------------------------------------------------------------------
// lsbc_pkg: shared types and constants of the load shed button controller
// Queue sizing, register indexes, reset values, event codes and beat types.
// ----------------------------------------------------------------------------
package lsbc_pkg;

  localparam int QUEUE_DEPTH   = 5;
  localparam int DURATION_BITS = 24;

  localparam int QA_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int DUR_W   = DURATION_BITS;
  localparam int PCT_W   = 7;
  localparam int ENTRY_W = PCT_W + DUR_W;
  localparam int CFG_W   = 24;
  localparam int CFG_IDX_W = 2;
  localparam int TICK_W  = 16;

  localparam logic [32:0] DUR_MAX = (33'd1 << DURATION_BITS) - 33'd1;
  localparam logic [TICK_W-1:0] TICK_MAX = '1;
  localparam logic [PCT_W-1:0]  PCT_FULL = 7'd100;
  localparam logic [7:0]        DUTY_FULL = 8'd255;

  // (100 - p) * 255 / 100 as a multiply by 255 * ceil(2^19 / 100) and a shift
  localparam logic [20:0] DUTY_MUL   = 21'd1336965;
  localparam int          DUTY_SHIFT = 19;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_PCT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_MS   = 2'd3;

  localparam logic [15:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [15:0] LONG_PRESS_RST = 16'd1500;
  localparam logic [6:0]  LOCAL_PCT_RST  = 7'd30;
  localparam logic [23:0] LOCAL_MS_RST   = 24'd5000;

  localparam logic [1:0] SHED_NONE          = 2'd0;
  localparam logic [1:0] SHED_STARTED       = 2'd1;
  localparam logic [1:0] SHED_ENDED         = 2'd2;
  localparam logic [1:0] SHED_ENDED_STARTED = 2'd3;

  localparam logic [1:0] RELAY_NONE   = 2'd0;
  localparam logic [1:0] RELAY_CLOSED = 2'd1;
  localparam logic [1:0] RELAY_OPENED = 2'd2;

  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_REMOTE = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic        button_level;
    logic        link_up;
    logic [6:0]  reduce_percent;
    logic [23:0] reduce_duration;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] pwm_duty;
    logic       relay_closed;
    logic [1:0] shed_event;
    logic [6:0] shed_load_pct;
    logic [1:0] relay_event;
    logic       broadcast_reduce;
    logic       command_dropped;
  } out_beat_t;

  typedef struct packed {
    logic              en;
    logic [QA_W-1:0]   addr;
    logic [ENTRY_W-1:0] data;
  } ram_wr_t;

  function automatic logic [PCT_W-1:0] sat_pct(logic [6:0] p);
    return (p > PCT_FULL) ? PCT_FULL : p;
  endfunction

  function automatic logic [DUR_W-1:0] sat_dur(logic [23:0] d);
    logic [32:0] w;
    w = 33'(d);
    if (w > DUR_MAX) begin
      w = DUR_MAX;
    end
    return DUR_W'(w);
  endfunction

endpackage

// ===== sv/lsbc_if.sv =====
// ----------------------------------------------------------------------------
// lsbc_if: valid/ready channels of the load shed button controller
// One interface for the input beat and one for the result beat.
// ----------------------------------------------------------------------------
interface lsbc_in_if;
  import lsbc_pkg::*;
  logic     valid;
  logic     ready;
  in_beat_t beat;
  modport source (output valid, output beat, input ready);
  modport sink (input valid, input beat, output ready);
endinterface

interface lsbc_out_if;
  import lsbc_pkg::*;
  logic      valid;
  logic      ready;
  out_beat_t beat;
  modport source (output valid, output beat, input ready);
  modport sink (input valid, input beat, output ready);
endinterface

// ===== sv/lsbc_ram.sv =====
// ----------------------------------------------------------------------------
// lsbc_ram: simple dual port RAM
// One write port, one read port, registered read data, old data on collision.
// ----------------------------------------------------------------------------
module lsbc_ram #(
  parameter int DEPTH = 5,
  parameter int WIDTH = 31,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/lsbc_core.sv =====
// ----------------------------------------------------------------------------
// lsbc_core: debounce, press classification and shed sequencing
// Updates the button and shed state per beat and drives the command queue RAM.
// ----------------------------------------------------------------------------
module lsbc_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [lsbc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lsbc_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                       acc_i,
  input  lsbc_pkg::in_beat_t         beat_i,
  output lsbc_pkg::out_beat_t        result_o,
  output lsbc_pkg::ram_wr_t          ram_wr_o,
  output logic [lsbc_pkg::QA_W-1:0]  ram_raddr_o,
  input  logic [lsbc_pkg::ENTRY_W-1:0] ram_rdata_i
);
  import lsbc_pkg::*;

  logic [15:0] debounce_q, long_press_q;
  logic [6:0]  local_pct_q;
  logic [23:0] local_ms_q;

  logic              raw_last_q, raw_last_d;
  logic              stable_q, stable_d;
  logic [TICK_W-1:0] since_q, since_d;
  logic [TICK_W-1:0] held_q, held_d;
  logic              relay_q, relay_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [QA_W-1:0]   head_q, head_d;
  logic              active_q, active_d;
  logic [DUR_W-1:0]  remain_q, remain_d;
  logic [7:0]        duty_q, duty_d;

  logic               fwd_q;
  logic [ENTRY_W-1:0] fwd_data_q;

  logic               tick, end_now, edge_seen, push_req, push, pop, full;
  logic [ENTRY_W-1:0] push_data, head_entry, stored_head;
  logic [PCT_W-1:0]   head_pct, remain_pct;
  logic [DUR_W-1:0]   head_dur;
  logic [27:0]        duty_prod;
  logic [QA_W:0]      slot_sum;
  logic [QA_W-1:0]    tail_slot;
  logic [CNT_W-1:0]   count_mid;

  assign tick = (beat_i.cmd == CMD_TICK);
  assign full = (count_q == CNT_W'(QUEUE_DEPTH));

  assign slot_sum  = (QA_W+1)'(head_q) + (QA_W+1)'(count_q);
  assign tail_slot = (slot_sum >= (QA_W+1)'(QUEUE_DEPTH)) ?
                     QA_W'(slot_sum - (QA_W+1)'(QUEUE_DEPTH)) : QA_W'(slot_sum);

  assign stored_head = fwd_q ? fwd_data_q : ram_rdata_i;
  assign head_entry  = (count_q == '0) ? push_data : stored_head;
  assign head_pct    = head_entry[ENTRY_W-1 -: PCT_W];
  assign head_dur    = head_entry[DUR_W-1:0];
  assign remain_pct  = PCT_FULL - head_pct;
  assign duty_prod   = 28'(remain_pct) * 28'(DUTY_MUL);

  always_comb begin
    raw_last_d = raw_last_q;
    stable_d   = stable_q;
    since_d    = since_q;
    held_d     = held_q;
    relay_d    = relay_q;
    count_d    = count_q;
    head_d     = head_q;
    active_d   = active_q;
    remain_d   = remain_q;
    duty_d     = duty_q;
    end_now    = 1'b0;
    edge_seen  = 1'b0;
    push_req   = 1'b0;
    push       = 1'b0;
    pop        = 1'b0;
    count_mid  = count_q;
    push_data  = {sat_pct(beat_i.reduce_percent), sat_dur(beat_i.reduce_duration)};
    result_o   = '0;

    if (acc_i) begin
      if (tick) begin
        if (active_q) begin
          if (remain_q <= DUR_W'(1)) begin
            end_now  = 1'b1;
            active_d = 1'b0;
            remain_d = '0;
            duty_d   = DUTY_FULL;
          end else begin
            remain_d = remain_q - DUR_W'(1);
          end
        end
        if (!stable_q && held_q != TICK_MAX) begin
          held_d = held_q + TICK_W'(1);
        end
        if (beat_i.button_level != raw_last_q) begin
          since_d = '0;
        end else if (since_q != TICK_MAX) begin
          since_d = since_q + TICK_W'(1);
        end
        raw_last_d = beat_i.button_level;
        edge_seen  = (since_d > debounce_q) && (beat_i.button_level != stable_q);
        if (edge_seen) begin
          stable_d = beat_i.button_level;
          if (!beat_i.button_level) begin
            held_d = '0;
          end else if (held_d >= long_press_q) begin
            relay_d    = !relay_q;
            result_o.relay_event = relay_d ? RELAY_CLOSED : RELAY_OPENED;
          end else if (beat_i.link_up) begin
            push_req = 1'b1;
            result_o.broadcast_reduce = 1'b1;
          end
        end
        push_data = {sat_pct(local_pct_q), sat_dur(local_ms_q)};
      end else begin
        push_req = 1'b1;
      end

      push = push_req && !full;
      result_o.command_dropped = push_req && full;
      count_mid = push ? count_q + CNT_W'(1) : count_q;

      pop = !active_d && (count_mid != '0);
      if (pop) begin
        count_d  = count_mid - CNT_W'(1);
        head_d   = (head_q == QA_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + QA_W'(1);
        active_d = 1'b1;
        remain_d = head_dur;
        duty_d   = duty_prod[DUTY_SHIFT +: 8];
        result_o.shed_load_pct = remain_pct;
      end else begin
        count_d = count_mid;
      end

      if (end_now && pop) begin
        result_o.shed_event = SHED_ENDED_STARTED;
      end else if (end_now) begin
        result_o.shed_event = SHED_ENDED;
      end else if (pop) begin
        result_o.shed_event = SHED_STARTED;
      end else begin
        result_o.shed_event = SHED_NONE;
      end
    end
    result_o.pwm_duty     = duty_d;
    result_o.relay_closed = relay_d;
  end

  assign ram_wr_o.en   = push;
  assign ram_wr_o.addr = tail_slot;
  assign ram_wr_o.data = push_data;
  assign ram_raddr_o   = head_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= DEBOUNCE_RST;
      long_press_q <= LONG_PRESS_RST;
      local_pct_q  <= LOCAL_PCT_RST;
      local_ms_q   <= LOCAL_MS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DEBOUNCE:   debounce_q   <= cfg_data_i[15:0];
        REG_LONG_PRESS: long_press_q <= cfg_data_i[15:0];
        REG_LOCAL_PCT:  local_pct_q  <= cfg_data_i[6:0];
        REG_LOCAL_MS:   local_ms_q   <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_last_q <= 1'b1;
      stable_q   <= 1'b1;
      since_q    <= '0;
      held_q     <= '0;
      relay_q    <= 1'b1;
      count_q    <= '0;
      head_q     <= '0;
      active_q   <= 1'b0;
      remain_q   <= '0;
      duty_q     <= DUTY_FULL;
      fwd_q      <= 1'b0;
    end else begin
      raw_last_q <= raw_last_d;
      stable_q   <= stable_d;
      since_q    <= since_d;
      held_q     <= held_d;
      relay_q    <= relay_d;
      count_q    <= count_d;
      head_q     <= head_d;
      active_q   <= active_d;
      remain_q   <= remain_d;
      duty_q     <= duty_d;
      fwd_q      <= push && (tail_slot == head_d);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= push_data;
  end

endmodule

// ===== sv/lsbc_out_buf.sv =====
// ----------------------------------------------------------------------------
// lsbc_out_buf: two-entry result buffer
// Output register plus skid register so input beats continue under stall.
// ----------------------------------------------------------------------------
module lsbc_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  lsbc_pkg::out_beat_t data_i,
  output logic                ready_o,
  lsbc_out_if.source          out_o
);
  import lsbc_pkg::*;

  logic      main_v_q, skid_v_q;
  out_beat_t main_q, skid_q;

  assign ready_o   = !skid_v_q;
  assign out_o.valid = main_v_q;
  assign out_o.beat  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (out_o.ready) begin
        skid_v_q <= 1'b0;
      end
    end else if (push_i) begin
      if (main_v_q && !out_o.ready) begin
        skid_v_q <= 1'b1;
      end else begin
        main_v_q <= 1'b1;
      end
    end else if (out_o.ready) begin
      main_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (out_o.ready) begin
        main_q <= skid_q;
      end
    end else if (push_i) begin
      if (main_v_q && !out_o.ready) begin
        skid_q <= data_i;
      end else begin
        main_q <= data_i;
      end
    end
  end

endmodule

// ===== sv/load_shed_button_controller.sv =====
// ----------------------------------------------------------------------------
// load_shed_button_controller: debounced button and load shed sequencer
// Result beats are registered: output register, or skid register on stall.
// Throughput: one input beat per cycle while the skid register is empty; a
// stalled output still takes one more beat into the skid before ready drops.
// The command queue lives in a registered-read RAM; head reads are forwarded.
// Reset: all control state and the registers return to their defaults at once.
// ----------------------------------------------------------------------------
module load_shed_button_controller (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lsbc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lsbc_pkg::CFG_W-1:0]     cfg_data_i,
  lsbc_in_if.sink                        in_i,
  lsbc_out_if.source                     out_o
);
  import lsbc_pkg::*;

  logic               acc, buf_ready;
  out_beat_t          result;
  ram_wr_t            ram_wr;
  logic [QA_W-1:0]    ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  assign in_i.ready = buf_ready;
  assign acc        = in_i.valid && buf_ready;

  lsbc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .acc_i       (acc),
    .beat_i      (in_i.beat),
    .result_o    (result),
    .ram_wr_o    (ram_wr),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  lsbc_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_wr.en),
    .waddr_i (ram_wr.addr),
    .wdata_i (ram_wr.data),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  lsbc_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (acc),
    .data_i  (result),
    .ready_o (buf_ready),
    .out_o   (out_o)
  );

endmodule

// ===== sv/lsbc_checker.sv =====
// ----------------------------------------------------------------------------
// lsbc_checker: port-level checks of the load shed button controller
// Event and field consistency of result beats, and output beat stability.
// ----------------------------------------------------------------------------
module lsbc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input lsbc_pkg::out_beat_t out_beat_i
);
  import lsbc_pkg::*;

  a_pct_only_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_beat_i.shed_event[0] |-> out_beat_i.shed_load_pct == '0)
    else $error("load percent reported without shed start");

  a_end_restores_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_beat_i.shed_event == SHED_ENDED |-> out_beat_i.pwm_duty == DUTY_FULL)
    else $error("shed ended without full duty");

  a_relay_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_beat_i.relay_event != RELAY_NONE |->
      (out_beat_i.relay_event == RELAY_CLOSED && out_beat_i.relay_closed) ||
      (out_beat_i.relay_event == RELAY_OPENED && !out_beat_i.relay_closed))
    else $error("relay report disagrees with relay state");

  a_long_or_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_beat_i.relay_event != RELAY_NONE |-> !out_beat_i.broadcast_reduce)
    else $error("press classified as both long and short");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_beat_i))
    else $error("stalled result beat changed");

endmodule

bind load_shed_button_controller lsbc_checker u_lsbc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_beat_i  (out_o.beat)
);

// ===== tb/load_shed_button_controller_tb.sv =====
// ----------------------------------------------------------------------------
// load_shed_button_controller_tb: self-checking bench of the load shed controller
// A directed table followed by shaped random traffic drives button ticks and
// remote reduce commands under eight register settings and four flow patterns.
// Every result beat is compared field by field against a table entry or an in-bench model.
// ----------------------------------------------------------------------------
module load_shed_button_controller_tb;
  import lsbc_pkg::*;

  typedef enum int {FLOW_FREE, FLOW_SRC_IDLE, FLOW_SNK_STALL, FLOW_BOTH} flow_e;

  typedef struct packed {
    logic [6:0]  pct;
    logic [23:0] dur;
  } shed_req_t;

  typedef struct {
    in_beat_t  beat;
    bit        fixed;
    out_beat_t want;
  } drow_t;

  typedef struct {
    logic [CFG_W-1:0] dbc;
    logic [CFG_W-1:0] lp;
    logic [CFG_W-1:0] pct;
    logic [CFG_W-1:0] ms;
    flow_e            flow;
  } setting_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_data;

  lsbc_in_if  in_if ();
  lsbc_out_if out_if ();

  load_shed_button_controller dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // register copies
  logic [15:0] dbc_reg  = DEBOUNCE_RST;
  logic [15:0] long_reg = LONG_PRESS_RST;
  logic [6:0]  lpct_reg = LOCAL_PCT_RST;
  logic [23:0] lms_reg  = LOCAL_MS_RST;

  // button, relay and shed state
  logic        btn_raw      = 1'b1;
  logic        btn_stable   = 1'b1;
  logic [15:0] btn_quiet    = '0;
  logic [15:0] press_len    = '0;
  logic        relay_mirror = 1'b1;
  logic        shed_on      = 1'b0;
  logic [23:0] shed_left    = '0;
  logic [7:0]  duty_now     = DUTY_FULL;
  shed_req_t   backlog [$];

  out_beat_t due_reports [$];

  int gap_pct   = 0;
  int stall_pct = 0;
  int fail_count = 0;
  int n_beats = 0, n_results = 0, n_starts = 0, n_relay = 0, n_bcast = 0, n_drop = 0;

  logic tgt_level = 1'b1;
  int   run_left  = 0;

  setting_t plan [8] = '{
    '{24'd0,       24'd0,       24'd0,       24'd0,        FLOW_FREE},
    '{24'd3,       24'd8,       24'hFFFF7F,  24'd5,        FLOW_SRC_IDLE},
    '{24'd1,       24'd5,       24'd45,      24'd1,        FLOW_SNK_STALL},
    '{24'hFFFFFF,  24'hABFFFF,  24'd100,     24'd3,        FLOW_BOTH},
    '{24'h120002,  24'd65535,   24'd70,      24'd12,       FLOW_FREE},
    '{24'd5,       24'd3,       24'd1,       24'd2,        FLOW_SRC_IDLE},
    '{24'd0,       24'd12,      24'd99,      24'd30,       FLOW_SNK_STALL},
    '{24'd2,       24'd6,       24'd20,      24'hFFFFFF,   FLOW_BOTH}
  };

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic enqueue(logic [6:0] p, logic [23:0] d);
    if (backlog.size() >= QUEUE_DEPTH) begin
      return 1'b1;
    end
    backlog.push_back(shed_req_t'{pct: p, dur: d});
    return 1'b0;
  endfunction

  function automatic out_beat_t shed_outcome(in_beat_t b);
    out_beat_t r;
    shed_req_t head;
    logic [6:0] left_pct;
    r = '0;
    if (b.cmd == CMD_TICK) begin
      if (shed_on) begin
        if (shed_left <= 24'd1) begin
          shed_on = 1'b0;
          shed_left = '0;
          duty_now = DUTY_FULL;
          r.shed_event = SHED_ENDED;
        end else begin
          shed_left = shed_left - 24'd1;
        end
      end
      if (!btn_stable && press_len != TICK_MAX) begin
        press_len = press_len + 16'd1;
      end
      if (b.button_level != btn_raw) begin
        btn_quiet = '0;
      end else if (btn_quiet != TICK_MAX) begin
        btn_quiet = btn_quiet + 16'd1;
      end
      btn_raw = b.button_level;
      if (btn_quiet > dbc_reg && b.button_level != btn_stable) begin
        btn_stable = b.button_level;
        if (!b.button_level) begin
          press_len = '0;
        end else if (press_len >= long_reg) begin
          relay_mirror = !relay_mirror;
          r.relay_event = relay_mirror ? RELAY_CLOSED : RELAY_OPENED;
        end else if (b.link_up) begin
          r.broadcast_reduce = 1'b1;
          r.command_dropped = enqueue((lpct_reg > PCT_FULL) ? PCT_FULL : lpct_reg, lms_reg);
        end
      end
    end else begin
      r.command_dropped = enqueue((b.reduce_percent > PCT_FULL) ? PCT_FULL : b.reduce_percent,
                                  b.reduce_duration);
    end
    if (!shed_on && backlog.size() != 0) begin
      head = backlog.pop_front();
      left_pct = PCT_FULL - head.pct;
      shed_left = head.dur;
      shed_on = 1'b1;
      duty_now = 8'((32'(left_pct) * 255) / 100);
      r.shed_load_pct = left_pct;
      r.shed_event = r.shed_event | SHED_STARTED;
    end
    r.pwm_duty = duty_now;
    r.relay_closed = relay_mirror;
    return r;
  endfunction

  function automatic drow_t row(logic c, logic lvl, logic link, logic [6:0] p, logic [23:0] d,
                                bit fixed = 1'b0, out_beat_t want = '0);
    drow_t r;
    r.beat = in_beat_t'{cmd: c, button_level: lvl, link_up: link, reduce_percent: p,
                        reduce_duration: d};
    r.fixed = fixed;
    r.want = want;
    return r;
  endfunction

  function automatic out_beat_t report_of(logic [7:0] duty, logic relay, logic [1:0] shed,
                                          logic [6:0] pct, logic [1:0] rev, logic bc,
                                          logic drop);
    return out_beat_t'{pwm_duty: duty, relay_closed: relay, shed_event: shed,
                       shed_load_pct: pct, relay_event: rev, broadcast_reduce: bc,
                       command_dropped: drop};
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t mismatch %s: got %0d, want %0d", $time, what, got, want);
    fail_count++;
  endtask

  task automatic check_report(out_beat_t got, out_beat_t want);
    if (got.pwm_duty !== want.pwm_duty)
      report_mismatch("pwm_duty", got.pwm_duty, want.pwm_duty);
    if (got.relay_closed !== want.relay_closed)
      report_mismatch("relay_closed", got.relay_closed, want.relay_closed);
    if (got.shed_event !== want.shed_event)
      report_mismatch("shed_event", got.shed_event, want.shed_event);
    if (got.shed_load_pct !== want.shed_load_pct)
      report_mismatch("shed_load_pct", got.shed_load_pct, want.shed_load_pct);
    if (got.relay_event !== want.relay_event)
      report_mismatch("relay_event", got.relay_event, want.relay_event);
    if (got.broadcast_reduce !== want.broadcast_reduce)
      report_mismatch("broadcast_reduce", got.broadcast_reduce, want.broadcast_reduce);
    if (got.command_dropped !== want.command_dropped)
      report_mismatch("command_dropped", got.command_dropped, want.command_dropped);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_DEBOUNCE:   dbc_reg = data[15:0];
      REG_LONG_PRESS: long_reg = data[15:0];
      REG_LOCAL_PCT:  lpct_reg = data[6:0];
      REG_LOCAL_MS:   lms_reg = data[23:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(logic [CFG_W-1:0] dbc, logic [CFG_W-1:0] lp,
                              logic [CFG_W-1:0] pct, logic [CFG_W-1:0] ms);
    put_reg(REG_DEBOUNCE, dbc);
    put_reg(REG_LONG_PRESS, lp);
    put_reg(REG_LOCAL_PCT, pct);
    put_reg(REG_LOCAL_MS, ms);
    cfg_we <= 1'b0;
  endtask

  task automatic send_beat(in_beat_t b, bit fixed, out_beat_t want);
    out_beat_t got;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.beat <= b;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    got = shed_outcome(b);
    due_reports.push_back(fixed ? want : got);
    n_beats++;
    if (got.shed_event[0]) n_starts++;
    if (got.relay_event != RELAY_NONE) n_relay++;
    if (got.broadcast_reduce) n_bcast++;
    if (got.command_dropped) n_drop++;
  endtask

  task automatic random_items(int n);
    in_beat_t b;
    int burst;
    int dq;
    int lq;
    int pick;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      b.reduce_percent = 7'($urandom_range(0, 127));
      b.reduce_duration = 24'($urandom());
      b.link_up = ($urandom_range(0, 99) < 80);
      if (burst == 0 && $urandom_range(0, 99) < 3) begin
        burst = $urandom_range(4, 8);
      end
      if (burst > 0 || $urandom_range(0, 99) < 10) begin
        if (burst > 0) burst--;
        b.cmd = CMD_REMOTE;
        b.button_level = 1'($urandom_range(0, 1));
        if (backlog.size() < QUEUE_DEPTH) begin
          pick = $urandom_range(0, 99);
          if (pick < 75) b.reduce_duration = 24'($urandom_range(0, 8));
          else if (pick < 95) b.reduce_duration = 24'($urandom_range(0, 60));
          else b.reduce_duration = 24'($urandom_range(0, 400));
        end
      end else begin
        b.cmd = CMD_TICK;
        if (run_left == 0) begin
          tgt_level = !tgt_level;
          dq = (dbc_reg > 30) ? 30 : int'(dbc_reg);
          lq = (long_reg > 40) ? 40 : int'(long_reg);
          if ($urandom_range(0, 9) == 0) begin
            run_left = $urandom_range(1, dq + 1);
          end else if (!tgt_level) begin
            run_left = dq + 2 + ($urandom_range(0, 1) ? $urandom_range(0, lq)
                                                     : lq + $urandom_range(0, 4));
          end else begin
            run_left = dq + 2 + $urandom_range(0, 12);
          end
        end
        run_left--;
        b.button_level = ($urandom_range(0, 99) < 3) ? !tgt_level : tgt_level;
      end
      send_beat(b, 1'b0, '0);
    end
  endtask

  initial begin
    drow_t rows [$];
    rst_n = 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= '0;
    cfg_data <= '0;
    in_if.valid <= 1'b0;
    in_if.beat <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    program_regs(24'd0, 24'd3, 24'd100, 24'd2);
    rows.push_back(row(CMD_TICK, 1, 0, 0, 0, 1,
                       report_of(255, 1, SHED_NONE, 0, RELAY_NONE, 0, 0)));
    rows.push_back(row(CMD_REMOTE, 1, 1, 0, 0, 1,
                       report_of(255, 1, SHED_STARTED, 100, RELAY_NONE, 0, 0)));
    rows.push_back(row(CMD_TICK, 1, 1, 127, 24'hFFFFFF, 1,
                       report_of(255, 1, SHED_ENDED, 0, RELAY_NONE, 0, 0)));
    rows.push_back(row(CMD_REMOTE, 0, 0, 100, 3, 1,
                       report_of(0, 1, SHED_STARTED, 0, RELAY_NONE, 0, 0)));
    rows.push_back(row(CMD_REMOTE, 1, 0, 127, 1));
    rows.push_back(row(CMD_REMOTE, 1, 0, 50, 1));
    rows.push_back(row(CMD_REMOTE, 1, 0, 1, 0));
    rows.push_back(row(CMD_REMOTE, 1, 0, 99, 2));
    rows.push_back(row(CMD_REMOTE, 1, 0, 0, 1));
    rows.push_back(row(CMD_REMOTE, 0, 1, 127, 24'hFFFFFF, 1,
                       report_of(0, 1, SHED_NONE, 0, RELAY_NONE, 0, 1)));
    rows.push_back(row(CMD_TICK, 0, 1, 0, 0));
    rows.push_back(row(CMD_TICK, 0, 1, 0, 0));
    rows.push_back(row(CMD_TICK, 0, 1, 0, 0));
    rows.push_back(row(CMD_TICK, 1, 1, 0, 0));
    rows.push_back(row(CMD_TICK, 1, 1, 0, 0, 1,
                       report_of(252, 0, SHED_ENDED_STARTED, 99, RELAY_OPENED, 0, 0)));
    rows.push_back(row(CMD_TICK, 0, 1, 0, 0));
    rows.push_back(row(CMD_TICK, 0, 1, 0, 0));
    rows.push_back(row(CMD_TICK, 1, 1, 0, 0));
    rows.push_back(row(CMD_TICK, 1, 1, 0, 0, 1,
                       report_of(0, 0, SHED_ENDED_STARTED, 0, RELAY_NONE, 1, 0)));
    rows.push_back(row(CMD_TICK, 1, 0, 0, 0));
    rows.push_back(row(CMD_TICK, 1, 0, 0, 0));
    rows.push_back(row(CMD_TICK, 0, 0, 0, 0));
    rows.push_back(row(CMD_TICK, 0, 0, 0, 0));
    rows.push_back(row(CMD_TICK, 1, 0, 0, 0));
    rows.push_back(row(CMD_TICK, 1, 0, 0, 0));
    foreach (rows[i]) send_beat(rows[i].beat, rows[i].fixed, rows[i].want);

    for (int p = 0; p < 8; p++) begin
      in_if.valid <= 1'b0;
      while (due_reports.size() != 0) @(posedge clk);
      program_regs(plan[p].dbc, plan[p].lp, plan[p].pct, plan[p].ms);
      case (plan[p].flow)
        FLOW_FREE:      begin gap_pct = 0;  stall_pct = 0;  end
        FLOW_SRC_IDLE:  begin gap_pct = 88; stall_pct = 0;  end
        FLOW_SNK_STALL: begin gap_pct = 0;  stall_pct = 88; end
        default:        begin gap_pct = 37; stall_pct = 37; end
      endcase
      random_items(160);
    end

    in_if.valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (due_reports.size() != 0) begin
      report_mismatch("results missing", due_reports.size(), 0);
    end
    $display("covered %0d beats over 8 settings, %0d results checked", n_beats, n_results);
    $display("sheds started %0d, relay reports %0d, broadcasts %0d, drops %0d",
             n_starts, n_relay, n_bcast, n_drop);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        n_results++;
        if (due_reports.size() == 0) begin
          report_mismatch("unexpected result, pwm_duty", out_if.beat.pwm_duty, 0);
        end else begin
          check_report(out_if.beat, due_reports.pop_front());
        end
      end
      out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
